// File: rtl/mf_pkg.sv
// Shared types and constants for the 3x3 median image filter.
// Used by the top level, mf_median and mf_result_queue; depends on nothing else.
package mf_pkg;

  localparam int PIX_W = 16;
  localparam int COL_W = 11;
  localparam int ROW_W = 16;
  localparam int CFG_AW = 3;

  localparam int QD = 16;
  localparam int QAW = $clog2(QD);
  localparam int QCW = $clog2(QD + 1);
  localparam int MAX_PUSH = 3;

  localparam logic CFG_IDX_WIDTH = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [11:0] WIDTH_RESET = 12'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;

  typedef struct packed {
    logic             left;
    logic             med;
    logic             right;
    logic             copy;
    logic             fend;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] col_m;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] row_m;
    logic [PIX_W-1:0] copy_pix;
    logic [PIX_W-1:0] border_pix;
  } meta_t;

  typedef struct packed {
    logic             fend;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic [PIX_W-1:0] pixel;
  } result_t;

endpackage

// File: rtl/median_3x3_image_filter.sv
// Top level of the 3x3 median image filter: counters, line buffer RAM, window,
// request credits and configuration registers. Uses mf_pkg, mf_ram, mf_median
// and mf_result_queue.
//
//  channel  direction  handshake              payload
//  in_      sink       in_tvalid/in_tready    tdata = pixel_in
//  out_     source     out_tvalid/out_tready  tdata, tlast = run_last, tuser = frame_end
//  cfg_     APB slave  psel/penable/pready    frame_width at 0, frame_height at 4
//
// One pixel is accepted per cycle while in_tready is high; each request makes one read
// and one write of the line buffer RAM, and its results reach the 16-entry result queue.
// in_tready drops while fewer than three queue entries are free of reservations.
// Reset clears counters, window, credits and queue; the line buffer is not cleared.
module median_3x3_image_filter #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // [15:0] pixel_in
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [47:0]                 out_tdata,  // [15:0] pixel_out, [26:16] out_column,
                                                  // [42:27] out_row, [47:43] zero
  output logic                        out_tlast,
  output logic [0:0]                  out_tuser,  // [0] frame_end
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mf_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WEW = (CW + 1 > 12) ? CW + 1 : 12;
  localparam logic [WEW-1:0] MAXW = WEW'(MAX_WIDTH);
  localparam logic [WEW-1:0] MINW = WEW'(3);

  typedef logic [mf_pkg::PIX_W-1:0] pix_t;

  logic [11:0]              width_r, width_nxt;
  logic [15:0]              height_r, height_nxt;
  logic                     cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    width_nxt = width_r;
    height_nxt = height_r;
    unique case (cfg_paddr[2])
      mf_pkg::CFG_IDX_WIDTH: begin
        cfg_prdata = {20'd0, width_r};
        if (cfg_wr) width_nxt = cfg_pwdata[11:0];
      end
      mf_pkg::CFG_IDX_HEIGHT: begin
        cfg_prdata = {16'd0, height_r};
        if (cfg_wr) height_nxt = cfg_pwdata[15:0];
      end
      default: cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= mf_pkg::WIDTH_RESET;
      height_r <= mf_pkg::HEIGHT_RESET;
    end else begin
      width_r <= width_nxt;
      height_r <= height_nxt;
    end
  end

  logic [WEW-1:0]           w_ext, w_eff;
  logic [CW-1:0]            wm1;
  logic [15:0]              h_eff, hm1;
  logic [CW-1:0]            col_r, col_nxt, c_eff;
  logic [15:0]              row_r, row_nxt, r_eff;
  logic                     acc;
  logic [1:0]               acc_n;
  mf_pkg::meta_t            acc_meta;
  logic [mf_pkg::QCW-1:0]   resv_r, resv_nxt;
  logic                     pop;

  always_comb begin
    w_ext = WEW'(width_r);
    w_eff = (w_ext < MINW) ? MINW : ((w_ext > MAXW) ? MAXW : w_ext);
    wm1 = CW'(w_eff - WEW'(1));
    h_eff = (height_r < 16'd3) ? 16'd3 : height_r;
    hm1 = h_eff - 16'd1;
    c_eff = (col_r > wm1) ? wm1 : col_r;
    r_eff = (row_r > hm1) ? hm1 : row_r;
  end

  assign acc = in_tvalid && in_tready;
  assign in_tready = (resv_r <= mf_pkg::QCW'(mf_pkg::QD - mf_pkg::MAX_PUSH));

  always_comb begin
    acc_meta.left = (r_eff >= 16'd2) && (c_eff == '0);
    acc_meta.med = (r_eff >= 16'd2) && (c_eff >= CW'(2));
    acc_meta.right = (r_eff >= 16'd2) && (c_eff == wm1);
    acc_meta.copy = (r_eff == 16'd0) || (r_eff == hm1);
    acc_meta.fend = (c_eff == wm1) && (r_eff == hm1);
    acc_meta.col = mf_pkg::COL_W'(c_eff);
    acc_meta.col_m = mf_pkg::COL_W'(c_eff - CW'(1));
    acc_meta.row = r_eff;
    acc_meta.row_m = r_eff - 16'd1;
    acc_meta.copy_pix = in_tdata;
    acc_meta.border_pix = '0;
    acc_n = 2'(acc_meta.left) + 2'(acc_meta.med) + 2'(acc_meta.right) + 2'(acc_meta.copy);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (c_eff == wm1) begin
        col_nxt = '0;
        row_nxt = (r_eff == hm1) ? 16'd0 : r_eff + 16'd1;
      end else begin
        col_nxt = c_eff + CW'(1);
        row_nxt = r_eff;
      end
    end
    resv_nxt = resv_r + (acc ? mf_pkg::QCW'(acc_n) : '0) - mf_pkg::QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      resv_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      resv_r <= resv_nxt;
    end
  end

  // Line buffer entry per column: [15:0] row above, [31:16] two rows above.
  logic                     v1_r;
  mf_pkg::meta_t            meta1_r;
  logic [CW-1:0]            addr1_r;
  logic [31:0]              lb_rdata;
  logic [31:0]              lb_wdata;

  assign lb_wdata = {lb_rdata[15:0], meta1_r.copy_pix};

  mf_ram #(
    .WIDTH(32),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (v1_r),
    .waddr (addr1_r),
    .wdata (lb_wdata),
    .re    (acc),
    .raddr (c_eff),
    .rdata (lb_rdata)
  );

  logic [8:0][mf_pkg::PIX_W-1:0] win_r, win_nxt;
  logic                          v2_r;
  mf_pkg::meta_t                 meta2_r, meta1_b;

  always_comb begin
    win_nxt = win_r;
    if (v1_r) begin
      for (int i = 0; i < 3; i++) begin
        win_nxt[i*3+0] = win_r[i*3+1];
        win_nxt[i*3+1] = win_r[i*3+2];
      end
      win_nxt[2] = lb_rdata[31:16];
      win_nxt[5] = lb_rdata[15:0];
      win_nxt[8] = meta1_r.copy_pix;
    end
    meta1_b = meta1_r;
    meta1_b.border_pix = lb_rdata[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      win_r <= '0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    meta1_r <= acc_meta;
    addr1_r <= c_eff;
    meta2_r <= meta1_b;
  end

  logic                     mv;
  mf_pkg::meta_t            mm;
  pix_t                     mmed;

  mf_median u_median (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .in_meta   (meta2_r),
    .in_win    (win_r),
    .out_valid (mv),
    .out_meta  (mm),
    .out_med   (mmed)
  );

  mf_pkg::result_t                          cand [4];
  logic [3:0]                               cand_en;
  mf_pkg::result_t [mf_pkg::MAX_PUSH-1:0]   push_data;
  logic [1:0]                               push_n;

  always_comb begin
    logic [2:0] k;
    cand[0] = '{fend: 1'b0, last: 1'b0, row: mm.row_m, column: '0, pixel: mm.border_pix};
    cand[1] = '{fend: 1'b0, last: 1'b0, row: mm.row_m, column: mm.col_m, pixel: mmed};
    cand[2] = '{fend: 1'b0, last: 1'b0, row: mm.row_m, column: mm.col, pixel: mm.border_pix};
    cand[3] = '{fend: mm.fend, last: 1'b0, row: mm.row, column: mm.col, pixel: mm.copy_pix};
    cand_en = {mm.copy, mm.right, mm.med, mm.left};
    push_data = '0;
    k = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_en[i] && (k < 3'(mf_pkg::MAX_PUSH))) begin
        push_data[k[1:0]] = cand[i];
        k = k + 3'd1;
      end
    end
    if (k != 3'd0) begin
      push_data[2'(k - 3'd1)].last = 1'b1;
    end
    push_n = mv ? k[1:0] : 2'd0;
  end

  mf_pkg::result_t          head;
  logic                     q_ne;

  mf_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (q_ne)
  );

  assign out_tvalid = q_ne;
  assign pop = out_tvalid && out_tready;
  assign out_tdata = {5'd0, head.row, head.column, head.pixel};
  assign out_tlast = head.last;
  assign out_tuser = head.fend;

  // The line buffer never reads the column that the previous request is writing back.
  a_no_ram_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && v1_r) |-> (c_eff != addr1_r))
    else $error("line buffer read and write hit the same column");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    resv_r <= mf_pkg::QCW'(mf_pkg::QD))
    else $error("result reservations exceed queue depth");

  a_valid_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (resv_r != '0))
    else $error("queued result without a reservation");

  a_pop_releases: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !acc) |=> (resv_r == $past(resv_r) - mf_pkg::QCW'(1)))
    else $error("delivered result did not release its reservation");

endmodule

// File: rtl/mf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module mf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/mf_median.sv
// Three-stage pipelined median of a 3x3 window, carrying request metadata along.
// Depends on mf_pkg for the metadata type and pixel width.
module mf_median (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  mf_pkg::meta_t                       in_meta,
  input  logic [8:0][mf_pkg::PIX_W-1:0]       in_win,
  output logic                                out_valid,
  output mf_pkg::meta_t                       out_meta,
  output logic [mf_pkg::PIX_W-1:0]            out_med
);

  typedef logic [mf_pkg::PIX_W-1:0] pix_t;

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  logic [2:0]    va_r, va_nxt;
  mf_pkg::meta_t ma_r, mb_r, mc_r;
  pix_t          lo_r [3];
  pix_t          mid_r [3];
  pix_t          hi_r [3];
  pix_t          lo_nxt [3];
  pix_t          mid_nxt [3];
  pix_t          hi_nxt [3];
  pix_t          maxlo_r, medmid_r, minhi_r;
  pix_t          med_r;

  always_comb begin
    pix_t l1, h1, m1;
    for (int j = 0; j < 3; j++) begin
      l1 = min2(in_win[j], in_win[3+j]);
      h1 = max2(in_win[j], in_win[3+j]);
      m1 = min2(h1, in_win[6+j]);
      hi_nxt[j] = max2(h1, in_win[6+j]);
      lo_nxt[j] = min2(l1, m1);
      mid_nxt[j] = max2(l1, m1);
    end
  end

  assign va_nxt = {va_r[1:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= '0;
    end else begin
      va_r <= va_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      lo_r[j] <= lo_nxt[j];
      mid_r[j] <= mid_nxt[j];
      hi_r[j] <= hi_nxt[j];
    end
    ma_r <= in_meta;
    maxlo_r <= max2(max2(lo_r[0], lo_r[1]), lo_r[2]);
    medmid_r <= med3(mid_r[0], mid_r[1], mid_r[2]);
    minhi_r <= min2(min2(hi_r[0], hi_r[1]), hi_r[2]);
    mb_r <= ma_r;
    med_r <= med3(maxlo_r, medmid_r, minhi_r);
    mc_r <= mb_r;
  end

  assign out_valid = va_r[2];
  assign out_meta = mc_r;
  assign out_med = med_r;

endmodule

// File: rtl/mf_result_queue.sv
// Result queue: takes up to three results per cycle in order, hands out one.
// Depends on mf_pkg for the result type and queue sizes.
module mf_result_queue (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic [1:0]                                push_n,
  input  mf_pkg::result_t [mf_pkg::MAX_PUSH-1:0]    push_data,
  input  logic                                      pop,
  output mf_pkg::result_t                           head,
  output logic                                      not_empty
);

  mf_pkg::result_t           store_r [mf_pkg::QD];
  logic [mf_pkg::QAW-1:0]    wp_r, wp_nxt;
  logic [mf_pkg::QAW-1:0]    rp_r, rp_nxt;
  logic [mf_pkg::QCW-1:0]    count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign head = store_r[rp_r];

  always_comb begin
    wp_nxt = wp_r + mf_pkg::QAW'(push_n);
    rp_nxt = rp_r + mf_pkg::QAW'(pop);
    count_nxt = count_r + mf_pkg::QCW'(push_n) - mf_pkg::QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      count_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < mf_pkg::MAX_PUSH; k++) begin
      if (k < int'(push_n)) begin
        store_r[wp_r + mf_pkg::QAW'(k)] <= push_data[k];
      end
    end
  end

endmodule
